### rtl/core/hilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hilt_pkg;

  // configuration register indexes
  localparam logic [3:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_IMAGE_HEIGHT = 4'd1;

  // removal limits on the black neighbor count
  localparam logic [3:0] MIN_BLACK = 4'd2;
  localparam logic [3:0] MAX_BLACK = 4'd6;
  localparam logic [3:0] ONE_TRANSITION = 4'd1;

  // neighbor ring, counter-clockwise from the top
  localparam int RING_DY [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
  localparam int RING_DX [8] = '{0, -1, -1, -1, 0, 1, 1, 1};

  typedef struct packed {
    logic centre;
    logic removed;
  } hilt_eval_t;

endpackage

`default_nettype wire

### rtl/core/hilditch_thinning_pass.sv
// channel  dir  handshake                   payload
// s        in   s_tvalid / s_tready         s_tdata: pixel_in; s_tuser: flush
// m        out  m_tvalid / m_tready         m_tdata: pixel_out, frame_changed;
//                                           m_tlast: frame_last
// cfg      in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one pixel per cycle sustained while the output is not stalled; a result passes
// through the window stage and then the result register before it is shown
// results lag the pixel stream by width+1 positions; send width+1 flush requests
// after each frame
// a stalled output holds one result and one more in the window stage
// rst clears position and window; the line store keeps its contents
`timescale 1ns / 1ps
`default_nettype none

module hilditch_thinning_pass #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] pixel_in
  input  wire logic [0:0]  s_tuser,   // [0] flush
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] pixel_out, [1] frame_changed
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RESET_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // clamped configuration
  logic [WW-1:0] width;
  logic [11:0]   height;

  // input position
  logic [CW-1:0] col;
  logic [12:0]   row;

  // line store
  logic [2:0]    mem [MAX_WIDTH];
  logic [2:0]    rd_data;
  logic          fwd_hit;
  logic [2:0]    fwd_data;
  logic [CW-1:0] rd_addr;

  logic [15:0]   window;

  // window stage
  logic          s1_valid;
  logic [11:0]   s1_cy;
  logic [CW-1:0] s1_cx;
  logic          s1_last;
  logic          removed_any;

  logic          out_valid;
  logic          out_pixel;
  logic          out_last;
  logic          out_changed;

  logic          s_acc;
  logic          cfg_we;
  logic          cfg_hit;
  logic          s1_adv;
  logic          pixel;
  logic [2:0]    old;
  logic [3:0]    newcol;
  logic [CW:0]   col_inc;
  logic          wrap;
  logic [CW-1:0] col_next;
  logic [12:0]   row_next;
  logic          has_out;
  logic [11:0]   cy;
  logic [CW-1:0] cx;
  logic          last0;
  logic [31:0]   cfg_w_ext;
  logic [WW-1:0] width_new;
  logic [11:0]   height_new;
  logic [3:0]    row_ok;
  logic [3:0]    col_ok;
  logic [15:0]   grid;
  hilt_pkg::hilt_eval_t ev;
  logic          changed_now;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we && (cfg_index == hilt_pkg::CFG_IMAGE_WIDTH
                                || cfg_index == hilt_pkg::CFG_IMAGE_HEIGHT);
  assign s1_adv    = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_adv;
  assign s_acc     = s_tvalid && s_tready;

  assign cfg_w_ext  = {21'd0, cfg_data[10:0]};
  assign width_new  = (cfg_w_ext == 32'd0) ? WW'(1) :
                      (cfg_w_ext > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w_ext);
  assign height_new = (cfg_data == 12'd0) ? 12'd1 : cfg_data;

  assign pixel  = s_tuser[0] ? 1'b0 : s_tdata[0];
  assign old    = fwd_hit ? fwd_data : rd_data;
  assign newcol = {pixel, old[0], old[1], old[2]};

  assign col_inc = {1'b0, col} + 1'b1;
  assign wrap    = ({{(32 - CW - 1){1'b0}}, col_inc} >= {{(32 - WW){1'b0}}, width});

  always_comb begin
    if (col != '0) begin
      has_out = (row != 13'd0);
      cy      = 12'(row - 13'd1);
      cx      = col - 1'b1;
    end else begin
      has_out = (row >= 13'd2);
      cy      = 12'(row - 13'd2);
      cx      = CW'(width - 1'b1);
    end
    last0 = has_out && (cy == height - 12'd1)
            && ({{(32 - CW){1'b0}}, cx} == {{(32 - WW){1'b0}}, width} - 32'd1);
    if (cfg_hit || (s_acc && last0)) begin
      col_next = '0;
      row_next = 13'd0;
    end else if (s_acc) begin
      col_next = wrap ? '0 : col_inc[CW-1:0];
      row_next = wrap ? row + 13'd1 : row;
    end else begin
      col_next = col;
      row_next = row;
    end
    rd_addr = col_next;
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      mem[col] <= {old[1:0], pixel};
    end
    rd_data  <= mem[rd_addr];
    fwd_data <= {old[1:0], pixel};
  end

  // window masking for positions outside the frame
  always_comb begin
    row_ok[0] = (s1_cy >= 12'd2);
    row_ok[1] = (s1_cy != 12'd0);
    row_ok[2] = 1'b1;
    row_ok[3] = (({1'b0, s1_cy} + 13'd1) < {1'b0, height});
    col_ok[0] = ({{(32 - CW){1'b0}}, s1_cx} >= 32'd2);
    col_ok[1] = (s1_cx != '0);
    col_ok[2] = 1'b1;
    col_ok[3] = (({{(32 - CW){1'b0}}, s1_cx} + 32'd1) < {{(32 - WW){1'b0}}, width});
    for (int dyi = 0; dyi < 4; dyi++) begin
      for (int dxi = 0; dxi < 4; dxi++) begin
        grid[dyi * 4 + dxi] = window[(3 - dxi) * 4 + dyi] & row_ok[dyi] & col_ok[dxi];
      end
    end
  end

  hilt_eval u_eval (
    .grid (grid),
    .res  (ev)
  );

  assign changed_now = removed_any || ev.removed;

  always_ff @(posedge clk) begin
    if (rst) begin
      width       <= WW'(RESET_WIDTH);
      height      <= 12'd1024;
      col         <= '0;
      row         <= 13'd0;
      fwd_hit     <= 1'b0;
      window      <= 16'd0;
      s1_valid    <= 1'b0;
      removed_any <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == hilt_pkg::CFG_IMAGE_WIDTH)) begin
        width <= width_new;
      end
      if (cfg_we && (cfg_index == hilt_pkg::CFG_IMAGE_HEIGHT)) begin
        height <= height_new;
      end
      if (cfg_hit) begin
        col         <= '0;
        row         <= 13'd0;
        removed_any <= 1'b0;
      end else begin
        col <= col_next;
        row <= row_next;
        if (s1_adv) begin
          removed_any <= s1_last ? 1'b0 : changed_now;
        end
      end
      fwd_hit <= s_acc && (col == rd_addr);
      if (s_acc) begin
        window   <= {window[11:0], newcol};
        s1_valid <= has_out;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_cy   <= cy;
      s1_cx   <= cx;
      s1_last <= last0;
    end
    if (s1_adv) begin
      out_pixel   <= ev.removed ? 1'b0 : ev.centre;
      out_last    <= s1_last;
      out_changed <= changed_now;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_changed, out_pixel};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

### rtl/core/hilt_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module hilt_eval (
  input  wire logic [15:0]       grid,
  output hilt_pkg::hilt_eval_t   res
);

  // grid bit (dy + 2) * 4 + (dx + 2), dy and dx in -2..1
  function automatic logic pix(input logic [15:0] g, input int dy, input int dx);
    int idx;
    idx = (dy + 2) * 4 + (dx + 2);
    return g[idx];
  endfunction

  function automatic logic [3:0] transitions(input logic [15:0] g, input int oy,
                                             input int ox);
    logic [3:0] n;
    logic a;
    logic b;
    int j;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      j = (i + 1) % 8;
      a = pix(g, oy + hilt_pkg::RING_DY[i], ox + hilt_pkg::RING_DX[i]);
      b = pix(g, oy + hilt_pkg::RING_DY[j], ox + hilt_pkg::RING_DX[j]);
      n = n + {3'd0, (!a && b)};
    end
    return n;
  endfunction

  logic [3:0] black;
  logic [3:0] t_c;
  logic [3:0] t_up;
  logic [3:0] t_left;
  logic p2, p4, p6, p8;
  logic side_up;
  logic side_left;

  always_comb begin
    black = 4'd0;
    for (int i = 0; i < 8; i++) begin
      black = black + {3'd0, pix(grid, hilt_pkg::RING_DY[i], hilt_pkg::RING_DX[i])};
    end
  end

  assign t_c    = transitions(grid, 0, 0);
  assign t_up   = transitions(grid, -1, 0);
  assign t_left = transitions(grid, 0, -1);

  assign p2 = pix(grid, -1, 0);
  assign p4 = pix(grid, 0, -1);
  assign p6 = pix(grid, 1, 0);
  assign p8 = pix(grid, 0, 1);

  assign side_up   = !(p2 && p4 && p8) || (t_up != hilt_pkg::ONE_TRANSITION);
  assign side_left = !(p2 && p4 && p6) || (t_left != hilt_pkg::ONE_TRANSITION);

  assign res.centre  = pix(grid, 0, 0);
  assign res.removed = res.centre && (black >= hilt_pkg::MIN_BLACK)
                       && (black <= hilt_pkg::MAX_BLACK)
                       && (t_c == hilt_pkg::ONE_TRANSITION) && side_up && side_left;

endmodule

`default_nettype wire

### rtl/core/hilt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hilt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [3:0] cfg_index
);

  logic seen_changed;
  logic m_acc;
  logic cfg_restart;

  assign m_acc       = m_tvalid && m_tready;
  assign cfg_restart = cfg_valid && cfg_ready
                       && (cfg_index == hilt_pkg::CFG_IMAGE_WIDTH
                           || cfg_index == hilt_pkg::CFG_IMAGE_HEIGHT);

  // frame_changed seen on an earlier pixel of the same frame
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_changed <= 1'b0;
    end else if (cfg_restart) begin
      seen_changed <= 1'b0;
    end else if (m_acc) begin
      seen_changed <= m_tlast ? 1'b0 : (seen_changed || m_tdata[1]);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_changed_sticky: assert property (@(posedge clk) disable iff (rst)
    m_acc && seen_changed |-> m_tdata[1])
    else $error("frame_changed dropped within a frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind hilditch_thinning_pass hilt_checker u_chk (.*);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_W = 1024;

  typedef struct packed {
    logic pixel;
    logic last;
    logic changed;
  } thinned_t;

  typedef struct packed {
    logic pix;
    logic fl;
  } src_pixel_t;

  typedef enum int {FRAME_FULL, FRAME_EARLY_FLUSH, FRAME_PAUSED, FRAME_ABORTED} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [7:0]  s_tdata = '0;   // [0] pixel_in
  logic [0:0]  s_tuser = '0;   // [0] flush
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [7:0] m_tdata;    // [0] pixel_out, [1] frame_changed
  wire logic   m_tlast;
  logic        cfg_valid = 1'b0;
  wire logic   cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  hilditch_thinning_pass #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // thinning predictor state
  logic [2:0]  col_hist [MAX_W];
  logic [15:0] win = '0;
  int          cur_col = 0;
  int          cur_row = 0;
  int unsigned out_cnt = 0;
  bit          removed_seen = 1'b0;
  logic [10:0] reg_width = 11'd1024;
  logic [11:0] reg_height = 12'd1024;
  int          cy, cx, fw, fh;

  thinned_t    thinned_q [$];
  src_pixel_t  pixel_feed [$];

  bit          gaps_on = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          pixels_removed = 0;
  int          frames_sent = 0;
  int          random_items = 0;
  src_pixel_t  nxt;
  thinned_t    got;
  thinned_t    want;

  function automatic int ring_y(int i);
    case (i)
      0, 1, 7: return -1;
      2, 6:    return 0;
      default: return 1;
    endcase
  endfunction

  function automatic int ring_x(int i);
    case (i)
      0, 4:    return 0;
      1, 2, 3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic bit win_px(int dy, int dx);
    int y, x;
    y = cy + dy;
    x = cx + dx;
    if (y < 0 || y >= fh || x < 0 || x >= fw) return 1'b0;
    return win[(1 - dx) * 4 + 2 + dy];
  endfunction

  function automatic int crossings(int oy, int ox);
    int n;
    int j;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      j = (i + 1) % 8;
      if (!win_px(oy + ring_y(i), ox + ring_x(i)) && win_px(oy + ring_y(j), ox + ring_x(j)))
        n++;
    end
    return n;
  endfunction

  task automatic restart_frame();
    cur_col = 0;
    cur_row = 0;
    out_cnt = 0;
    removed_seen = 1'b0;
  endtask

  task automatic cfg_apply(input logic [3:0] idx, input logic [11:0] val);
    if (idx == hilt_pkg::CFG_IMAGE_WIDTH) begin
      reg_width = val[10:0];
      restart_frame();
    end else if (idx == hilt_pkg::CFG_IMAGE_HEIGHT) begin
      reg_height = val;
      restart_frame();
    end
  endtask

  task automatic thin_step(input logic pix_in, input logic is_flush);
    int w, h, c, r, nz;
    logic p, centre, p2, p4, p6, p8, rm, last;
    logic [2:0] old;
    thinned_t res;
    w = int'(reg_width);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = int'(reg_height);
    if (h == 0) h = 1;
    fw = w;
    fh = h;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    p = is_flush ? 1'b0 : pix_in;
    c = cur_col;
    r = cur_row;
    old = col_hist[c];
    win = {win[11:0], p, old[0], old[1], old[2]};
    col_hist[c] = {old[1:0], p};
    if (c >= 1) begin
      cy = r - 1;
      cx = c - 1;
    end else begin
      cy = r - 2;
      cx = w - 1;
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cy < 0) return;
    nz = 0;
    for (int i = 0; i < 8; i++) nz += int'(win_px(ring_y(i), ring_x(i)));
    p2 = win_px(-1, 0);
    p4 = win_px(0, -1);
    p6 = win_px(1, 0);
    p8 = win_px(0, 1);
    centre = win_px(0, 0);
    rm = centre && nz >= hilt_pkg::MIN_BLACK && nz <= hilt_pkg::MAX_BLACK
         && crossings(0, 0) == hilt_pkg::ONE_TRANSITION
         && (!(p2 && p4 && p8) || crossings(-1, 0) != hilt_pkg::ONE_TRANSITION)
         && (!(p2 && p4 && p6) || crossings(0, -1) != hilt_pkg::ONE_TRANSITION);
    if (rm) begin
      removed_seen = 1'b1;
      pixels_removed++;
    end
    out_cnt = (out_cnt + 1) & 32'h3F_FFFF;
    last = (out_cnt >= w * h);
    res.pixel = rm ? 1'b0 : centre;
    res.last = last;
    res.changed = removed_seen;
    thinned_q.push_back(res);
    if (last) restart_frame();
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        thin_step(s_tdata[0], s_tuser[0]);
        items_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          nxt = pixel_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, nxt.pix};
          s_tuser <= nxt.fl;
          gap_left = gaps_on ? $urandom_range(0, 15) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.pixel = m_tdata[0];
        got.last = m_tlast;
        got.changed = m_tdata[1];
        if (thinned_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: pixel %b last %b changed %b",
                     got.pixel, got.last, got.changed);
        end else begin
          want = thinned_q.pop_front();
          results_checked++;
          if (got.pixel !== want.pixel || got.last !== want.last ||
              got.changed !== want.changed) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at result %0d: exp pixel %b last %b changed %b, got %b %b %b",
                       results_checked, want.pixel, want.last, want.changed,
                       got.pixel, got.last, got.changed);
          end
        end
        stall_left = gaps_on ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_px(input logic pix, input logic fl);
    src_pixel_t it;
    it.pix = pix;
    it.fl = fl;
    pixel_feed.push_back(it);
  endtask

  // wait until every request is taken and every result is back, then let the pipe empty
  task automatic settle();
    while (pixel_feed.size() > 0 || s_tvalid || thinned_q.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [11:0] val);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_apply(idx, val);
  endtask

  function automatic logic rand_px(int density);
    return $urandom_range(0, 99) < density;
  endfunction

  task automatic send_frame(input int w, input int h, input int density,
                            input frame_kind_t kind, output int sent);
    int area, total, k;
    area = w * h;
    total = area + w + 1;
    sent = 0;
    case (kind)
      FRAME_EARLY_FLUSH: begin
        k = $urandom_range(0, area - 1);
        for (int i = 0; i < total; i++) begin
          if (i < k) push_px(rand_px(density), 1'b0);
          else if (i < area) push_px(1'($urandom_range(0, 1)), 1'b1);
          else push_px(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        sent = total;
      end
      FRAME_ABORTED: begin
        k = $urandom_range(0, total - 1);
        for (int i = 0; i < k; i++) push_px(rand_px(density), $urandom_range(0, 7) == 0);
        settle();
        sent = k;
      end
      default: begin
        for (int i = 0; i < total; i++) begin
          if (kind == FRAME_PAUSED && i == area / 2) settle();
          if (i < area) push_px(rand_px(density), 1'b0);
          else push_px(1'($urandom_range(0, 1)), 1'b1);
        end
        sent = total;
      end
    endcase
    frames_sent++;
  endtask

  initial begin
    int n, w, h, wv, hv, pick;
    bit need_cfg;
    frame_kind_t kind;
    for (int i = 0; i < MAX_W; i++) col_hist[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one-pixel frame
    gaps_on = 1'b1;
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'd1);
    push_px(1'b1, 1'b0);
    push_px(1'b0, 1'b1);
    push_px(1'b1, 1'b1);

    // zero sizes act as one, flush overrides a black pixel
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'd0);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'd0);
    push_px(1'b1, 1'b0);
    push_px(1'b1, 1'b1);
    push_px(1'b1, 1'b1);

    // early flush inside the frame, then plain pixels past its end
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'd3);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'd3);
    repeat (7) push_px(1'b1, 1'b0);
    repeat (2) push_px(1'b1, 1'b1);
    repeat (2) push_px(1'b1, 1'b0);
    repeat (2) push_px(1'b1, 1'b1);

    // frame cut short by a register write
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'd2);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'd4);
    repeat (3) push_px(1'b1, 1'b0);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'd2);
    repeat (4) push_px(1'b1, 1'b0);
    repeat (3) push_px(1'b0, 1'b1);

    // oversize width that clamps and the largest height, each cut short by a write
    gaps_on = 1'b0;
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'hFFF);
    write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, 12'hFFF);
    repeat (30) push_px(rand_px(60), 1'b0);
    write_reg(hilt_pkg::CFG_IMAGE_WIDTH, 12'd1);
    repeat (30) push_px(rand_px(70), 1'b0);

    need_cfg = 1'b1;
    w = 1;
    h = 4095;
    while (random_items < 500) begin
      gaps_on = $urandom_range(0, 3) != 0;
      if (need_cfg || $urandom_range(0, 1)) begin
        if ($urandom_range(0, 7) == 0) w = $urandom_range(9, 64);
        else w = $urandom_range(1, 8);
        h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 8);
        wv = w;
        hv = h;
        if (w == 1 && $urandom_range(0, 1)) wv = 0;
        if (h == 1 && $urandom_range(0, 1)) hv = 0;
        write_reg(hilt_pkg::CFG_IMAGE_WIDTH, wv[11:0]);
        write_reg(hilt_pkg::CFG_IMAGE_HEIGHT, hv[11:0]);
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0:       kind = FRAME_ABORTED;
        1, 2:    kind = FRAME_EARLY_FLUSH;
        3:       kind = FRAME_PAUSED;
        default: kind = FRAME_FULL;
      endcase
      send_frame(w, h, $urandom_range(0, 100), kind, n);
      random_items += n;
      need_cfg = (kind == FRAME_ABORTED);
    end

    settle();
    repeat (20) @(negedge clk);
    if (thinned_q.size() > 0) begin
      $display("%0d expected results never arrived", thinned_q.size());
      fail_count += thinned_q.size();
    end
    $display("%0d pixels sent in %0d frames, %0d thinned pixels checked",
             items_sent, frames_sent, results_checked);
    $display("%0d pixels removed; sizes from 1x1 up to 64 wide, clamped width and tallest frame",
             pixels_removed);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for thinned pixels");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
